>>> rtl/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and the per-byte scanner for the source comment stripper.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_NL     = 8'h0A;

  localparam int unsigned QDEPTH = 3;

  typedef struct packed {
    logic esc;
    logic str;
    logic chr;
    logic lcmt;
    logic bcmt;
  } scan_state_t;

  typedef struct packed {
    scan_state_t st;
    logic        emit;
    logic        took;
  } scan_res_t;

  typedef struct packed {
    logic       done;
    logic       run_last;
    logic       has_byte;
    logic [7:0] kept;
  } result_t;

  // One byte c against the lexer flags; took means the successor nx was
  // consumed as the second half of a two-byte marker.
  function automatic scan_res_t scan_byte(scan_state_t s, logic [7:0] c,
                                          logic has_nx, logic [7:0] nx);
    scan_res_t r;
    logic      in_cmt;
    r        = '0;
    r.st     = s;
    in_cmt   = s.lcmt | s.bcmt;
    if (s.esc) begin
      r.st.esc = 1'b0;
      r.emit   = !in_cmt;
    end else if (c == CH_BSLASH && (s.str || s.chr)) begin
      r.st.esc = 1'b1;
      r.emit   = !in_cmt;
    end else if (!in_cmt && c == CH_DQUOTE && !s.chr) begin
      r.st.str = !s.str;
      r.emit   = 1'b1;
    end else if (!in_cmt && c == CH_SQUOTE && !s.str) begin
      r.st.chr = !s.chr;
      r.emit   = 1'b1;
    end else if (s.str || s.chr) begin
      r.emit   = !in_cmt;
    end else if (!s.bcmt && has_nx && c == CH_SLASH && nx == CH_SLASH) begin
      r.st.lcmt = 1'b1;
      r.took    = 1'b1;
    end else if (!s.lcmt && has_nx && c == CH_SLASH && nx == CH_STAR) begin
      r.st.bcmt = 1'b1;
      r.took    = 1'b1;
    end else if (s.lcmt && c == CH_NL) begin
      r.st.lcmt = 1'b0;
      r.emit    = 1'b1;
    end else if (s.bcmt && has_nx && c == CH_STAR && nx == CH_SLASH) begin
      r.st.bcmt = 1'b0;
      r.took    = 1'b1;
    end else begin
      r.emit = !in_cmt;
    end
    return r;
  endfunction

endpackage

>>> rtl/source_comment_stripper_unit.sv
// ----------------------------------------------------------------------------
// source_comment_stripper_unit
// Streams source text and drops line and block comments, keeping strings,
// character literals and escapes intact.
// ----------------------------------------------------------------------------
// Input channel s_*: one text byte per transfer, s_tlast on the final byte.
// Output channel m_*: kept bytes; m_tuser[0] says a byte is present (clear
// only on a bare end marker), m_tuser[1] marks the last result of an input
// transfer, m_tlast marks the final result of the text.
// One byte is held back, so a kept byte appears one input transfer after it
// arrives; the final transfer flushes it and may give two results.
// A result is written into the registered result queue by the transfer that
// causes it. The input takes one transfer per cycle while the receiver keeps
// up and results average at most one per input; a three-entry result queue
// decouples the sides and s_tready is high while at most one entry is occupied,
// so a final transfer with two results holds off input until an entry is taken.
// Reset clears the lexer flags, the held byte and the queue.
// When the receiver stalls the queue fills and s_tready drops; nothing is
// lost or reordered. After the final byte all lexer state returns to reset.
// ----------------------------------------------------------------------------
module source_comment_stripper_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // text_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] kept_byte
  output logic [1:0] m_tuser,   // [0] has_byte, [1] run_last
  output logic       m_tlast    // stream_done
);
  import scs_pkg::*;

  scan_state_t st, st_next;
  logic [7:0]  held_byte, held_byte_next;
  logic        held_valid, held_valid_next;
  result_t     q [QDEPTH];
  result_t     q_next [QDEPTH];
  logic [1:0]  count, count_next;

  scan_res_t   r1, r2;
  scan_state_t st1;
  logic        e1, e2, hv, accept, pop;
  logic [7:0]  hb;
  logic [1:0]  num, base;
  result_t     ent_a, ent_b, push0;

  assign s_tready = (count <= 2'd1);
  assign m_tvalid = (count != 2'd0);
  assign accept   = s_tvalid && s_tready;
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = q[0].kept;
  assign m_tuser  = {q[0].run_last, q[0].has_byte};
  assign m_tlast  = q[0].done;

  always_comb begin
    r1  = scan_byte(st, held_byte, 1'b1, s_tdata);
    st1 = held_valid ? r1.st : st;
    e1  = held_valid && r1.emit;
    hv  = !(held_valid && r1.took);
    hb  = (held_valid && r1.took) ? held_byte : s_tdata;
    r2  = scan_byte(st1, hb, 1'b0, 8'h00);
    e2  = s_tlast && hv && r2.emit;

    ent_a.kept     = held_byte;
    ent_a.has_byte = 1'b1;
    ent_a.run_last = !(s_tlast && e2);
    ent_a.done     = s_tlast && !e2;

    ent_b.kept     = e2 ? hb : 8'h00;
    ent_b.has_byte = e2;
    ent_b.run_last = 1'b1;
    ent_b.done     = 1'b1;

    push0 = e1 ? ent_a : ent_b;
    num   = {1'b0, e1} + {1'b0, s_tlast && (e2 || !e1)};
  end

  always_comb begin
    st_next         = st;
    held_byte_next  = held_byte;
    held_valid_next = held_valid;
    if (accept) begin
      if (s_tlast) begin
        st_next         = '0;
        held_byte_next  = 8'h00;
        held_valid_next = 1'b0;
      end else begin
        st_next         = st1;
        held_byte_next  = hb;
        held_valid_next = hv;
      end
    end
  end

  always_comb begin
    base       = count - {1'b0, pop};
    count_next = accept ? base + num : base;
    for (int i = 0; i < QDEPTH; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_next[i] = q[i + 1];
      end
    end
    for (int i = 0; i < QDEPTH; i++) begin
      if (accept && num != 2'd0 && base == i[1:0]) begin
        q_next[i] = push0;
      end
      if (accept && num == 2'd2 && base + 2'd1 == i[1:0]) begin
        q_next[i] = ent_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= '0;
      held_byte  <= 8'h00;
      held_valid <= 1'b0;
      count      <= 2'd0;
    end else begin
      st         <= st_next;
      held_byte  <= held_byte_next;
      held_valid <= held_valid_next;
      count      <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

>>> rtl/scs_checker.sv
// ----------------------------------------------------------------------------
// scs_checker
// Port-level checks for the source comment stripper, bound to the top level.
// ----------------------------------------------------------------------------
module scs_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);
  import scs_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_bare_marker: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && m_tdata == 8'h00)
    else $error("bare marker not a clean stream end");

  a_done_is_run_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[1])
    else $error("stream end without run end");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled output transfer changed");

endmodule

bind source_comment_stripper_unit scs_checker u_scs_checker (.*);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams through source_comment_stripper_unit and checks every
// output transfer against an in-bench comment-stripping predictor.
// Directed texts cover the byte extremes, markers at text end, nested
// slash-star, escapes in strings and chars and bare end markers. Random texts
// are built from comment, string, char and plain tokens, with raw noise.
// Four idle phases, plus one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
  import scs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 380;
  localparam int SEND_IDLE [4] = '{0, 58, 0, 37};
  localparam int RECV_STALL [4] = '{0, 0, 58, 37};

  typedef struct {
    logic [7:0] ch;
    logic       fin;
    int         phase;
  } text_item_t;

  typedef struct {
    logic [7:0] kept;
    logic       has;
    logic       run_last;
    logic       done;
  } strip_res_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [1:0] m_tuser;
  logic       m_tlast;

  text_item_t pending [$];
  strip_res_t stripped_q [$];
  strip_res_t want;

  // predictor state
  logic [7:0] held_ch;
  bit         held_ok;
  bit         esc_f, str_f, chr_f, lcmt_f, bcmt_f;

  int cur_phase = 0;
  int xfer_count = 0;
  int hold_left = 0;
  bit hold_used = 1'b0;
  int cyc = 0;
  int errors = 0;
  int results_seen = 0;
  int bare_seen = 0;
  int texts_done = 0;

  source_comment_stripper_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_lexer();
    held_ch = 8'h00;
    held_ok = 1'b0;
    esc_f   = 1'b0;
    str_f   = 1'b0;
    chr_f   = 1'b0;
    lcmt_f  = 1'b0;
    bcmt_f  = 1'b0;
  endfunction

  // Returns 1 when nx is swallowed as the second half of a marker.
  function automatic bit lex_char(logic [7:0] c, bit has_nx, logic [7:0] nx,
                                  output bit keep);
    bit quiet;
    quiet = lcmt_f | bcmt_f;
    keep  = 1'b0;
    if (esc_f) begin
      esc_f = 1'b0;
      keep  = !quiet;
      return 1'b0;
    end
    if (c == CH_BSLASH && (str_f || chr_f)) begin
      esc_f = 1'b1;
      keep  = !quiet;
      return 1'b0;
    end
    if (!quiet && c == CH_DQUOTE && !chr_f) begin
      str_f = !str_f;
      keep  = 1'b1;
      return 1'b0;
    end
    if (!quiet && c == CH_SQUOTE && !str_f) begin
      chr_f = !chr_f;
      keep  = 1'b1;
      return 1'b0;
    end
    if (str_f || chr_f) begin
      keep = !quiet;
      return 1'b0;
    end
    if (has_nx && c == CH_SLASH && nx == CH_SLASH && !bcmt_f) begin
      lcmt_f = 1'b1;
      return 1'b1;
    end
    if (has_nx && c == CH_SLASH && nx == CH_STAR && !lcmt_f) begin
      bcmt_f = 1'b1;
      return 1'b1;
    end
    if (lcmt_f && c == CH_NL) begin
      lcmt_f = 1'b0;
      keep   = 1'b1;
      return 1'b0;
    end
    if (has_nx && bcmt_f && c == CH_STAR && nx == CH_SLASH) begin
      bcmt_f = 1'b0;
      return 1'b1;
    end
    keep = !quiet;
    return 1'b0;
  endfunction

  function automatic void strip_step(logic [7:0] b, logic fin);
    logic [7:0] outb [2];
    int         n;
    bit         keep;
    bit         took;
    strip_res_t r;
    n = 0;
    if (held_ok) begin
      took = lex_char(held_ch, 1'b1, b, keep);
      if (keep) begin
        outb[n] = held_ch;
        n++;
      end
      if (took) begin
        held_ok = 1'b0;
      end else begin
        held_ch = b;
      end
    end else begin
      held_ch = b;
      held_ok = 1'b1;
    end
    if (fin) begin
      if (held_ok) begin
        void'(lex_char(held_ch, 1'b0, 8'h00, keep));
        if (keep) begin
          outb[n] = held_ch;
          n++;
        end
      end
      clear_lexer();
      if (n == 0) begin
        r = '{kept: 8'h00, has: 1'b0, run_last: 1'b1, done: 1'b1};
        stripped_q.push_back(r);
      end
    end
    for (int k = 0; k < n; k++) begin
      r.kept     = outb[k];
      r.has      = 1'b1;
      r.run_last = (k == n - 1);
      r.done     = fin && (k == n - 1);
      stripped_q.push_back(r);
    end
  endfunction

  function automatic void add_byte(logic [7:0] b, logic fin, int ph);
    text_item_t it;
    it.ch    = b;
    it.fin   = fin;
    it.phase = ph;
    pending.push_back(it);
  endfunction

  function automatic void add_string(string s, int ph);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], i == s.len() - 1, ph);
  endfunction

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 8'h61 + 8'($urandom_range(25));
    if (r < 48) return CH_SLASH;
    if (r < 56) return CH_STAR;
    if (r < 62) return CH_BSLASH;
    if (r < 68) return CH_DQUOTE;
    if (r < 74) return CH_SQUOTE;
    if (r < 80) return CH_NL;
    if (r < 88) return 8'h20;
    return 8'($urandom_range(255));
  endfunction

  // Mostly token-structured texts; one in ten is raw noise.
  function automatic int random_text(int ph);
    logic [7:0] txt [$];
    int         len;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(20, 1)) txt.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(8, 1)) begin
        len = $urandom_range(6);
        case ($urandom_range(5))
          0: begin
            repeat (len + 1) txt.push_back(text_char());
          end
          1: begin
            txt.push_back(CH_SLASH);
            txt.push_back(CH_SLASH);
            repeat (len) txt.push_back(text_char());
            txt.push_back(CH_NL);
          end
          2: begin
            txt.push_back(CH_SLASH);
            txt.push_back(CH_STAR);
            repeat (len) txt.push_back(text_char());
            txt.push_back(CH_STAR);
            txt.push_back(CH_SLASH);
          end
          3: begin
            txt.push_back(CH_DQUOTE);
            repeat (len) txt.push_back(text_char());
            txt.push_back(CH_DQUOTE);
          end
          4: begin
            txt.push_back(CH_SQUOTE);
            if ($urandom_range(1)) txt.push_back(CH_BSLASH);
            txt.push_back(text_char());
            txt.push_back(CH_SQUOTE);
          end
          default: begin
            txt.push_back(CH_NL);
          end
        endcase
      end
    end
    foreach (txt[i]) add_byte(txt[i], i == txt.size() - 1, ph);
    return txt.size();
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      errors++;
    end
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        strip_step(s_tdata, s_tlast);
        xfer_count <= xfer_count + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending.size() != 0 &&
            $urandom_range(99) >= SEND_IDLE[pending[0].phase]) begin
          s_tvalid  <= 1'b1;
          s_tdata   <= pending[0].ch;
          s_tlast   <= pending[0].fin;
          cur_phase <= pending[0].phase;
          void'(pending.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off while the sender keeps offering
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (!hold_used && xfer_count == 200) begin
      hold_left <= 120;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (stripped_q.size() == 0) begin
          $error("unexpected transfer: kept_byte %h tuser %b tlast %b",
                 m_tdata, m_tuser, m_tlast);
          errors++;
        end else begin
          want = stripped_q.pop_front();
          check_field("kept_byte", want.kept, m_tdata);
          check_field("has_byte", {7'd0, want.has}, {7'd0, m_tuser[0]});
          check_field("run_last", {7'd0, want.run_last}, {7'd0, m_tuser[1]});
          check_field("stream_done", {7'd0, want.done}, {7'd0, m_tlast});
          results_seen++;
          if (!want.has) bare_seen++;
          if (want.done) texts_done++;
        end
      end
      m_tready <= (hold_left == 0) && ($urandom_range(99) >= RECV_STALL[cur_phase]);
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cyc, stripped_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int n;
    int total_bytes;
    clear_lexer();
    // byte extremes; two results from the final transfer
    add_byte(8'h00, 1'b0, 0);
    add_byte(8'hFF, 1'b1, 0);
    // lone slash at text end stays a plain byte
    add_string("/", 0);
    // line comment keeps its newline
    add_string("//\n", 0);
    // slash-star inside a block comment is consumed as a pair
    add_string("/*/**/k", 0);
    // escaped quote and comment markers inside a string
    add_string("\"\\\"//\"", 0);
    // escaped quote in a char literal, then slash at end
    add_string("'\\''/", 0);
    // nothing kept: bare end marker
    add_string("/**/", 0);
    for (int ph = 0; ph < 4; ph++) begin
      n = 0;
      while (n < PHASE_BYTES) n += random_text(ph);
    end
    total_bytes = pending.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (xfer_count < total_bytes) @(posedge clk);
    while (stripped_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Streamed %0d bytes in %0d texts over four idle phases and one long hold-off.",
             xfer_count, texts_done);
    $display("Checked %0d output transfers, %0d of them bare end markers.",
             results_seen, bare_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
